@@ hw/rtl/gbn_snd_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_snd_pkg
// Shared types and constants for the Go-Back-N sender window unit.
// ----------------------------------------------------------------------------
package gbn_snd_pkg;

  // Sequence space; a power of two, so modular sums wrap in SEQ_BITS bits
  localparam int SEQ_SPACE        = 8;
  localparam int SEQ_BITS         = $clog2(SEQ_SPACE);
  localparam int MAX_RESULTS      = 7;
  localparam int WIN_BITS         = 3;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(4);
  localparam logic [WIN_BITS-1:0] WIN_MAX      = WIN_BITS'(SEQ_SPACE - 1);

  // Input action codes; the fourth code means nothing and is ignored
  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2
  } action_t;

  // Timer commands carried on each result
  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_cmd_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_RETX
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // take the input item and load its first result
    logic step;    // load the next retransmission of a timeout run
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_valid;  // output register holds a result
    logic multi;      // presented item is a timeout with more than one result
    logic retx_last;  // current retransmission is the final one of the run
  } dp_status_t;

endpackage

@@ hw/rtl/gbn_snd_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbn_snd_ctrl
// Controller: input flow control and sequencing of timeout retransmissions.
// ----------------------------------------------------------------------------
module gbn_snd_ctrl import gbn_snd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // Output register can take a new result this cycle
  assign out_free = !status.out_valid || !out_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = !out_free;
        cmd.accept = in_valid && out_free;
        if (cmd.accept && status.multi) begin
          state_next = ST_RETX;
        end
      end
      ST_RETX: begin
        if (out_free) begin
          cmd.step = 1'b1;
          if (status.retx_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/gbn_snd_dp.sv @@
// ----------------------------------------------------------------------------
// gbn_snd_dp
// Datapath: window state, payload store, result formation and output register.
// ----------------------------------------------------------------------------
module gbn_snd_dp import gbn_snd_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [WIN_BITS-1:0]     cfg_data,
  input  logic [1:0]              action,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  logic [SEQ_BITS-1:0]     ack_number,
  input  logic                    ack_intact,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    accepted,
  output logic                    tx_valid,
  output logic [SEQ_BITS-1:0]     tx_seq,
  output logic [PAYLOAD_BITS-1:0] tx_payload,
  output logic [1:0]              timer_cmd,
  output logic [SEQ_BITS-1:0]     timer_seq,
  output logic                    last
);

  logic [WIN_BITS-1:0]     window_size;
  logic [SEQ_BITS-1:0]     window_base;
  logic [SEQ_BITS-1:0]     next_sequence;
  logic [SEQ_BITS-1:0]     idx;
  logic [SEQ_BITS-1:0]     cnt;
  logic [PAYLOAD_BITS-1:0] payload_store [SEQ_SPACE];

  action_t                 act;
  logic [SEQ_BITS-1:0]     outstanding;
  logic [SEQ_BITS-1:0]     eff_win;
  logic [SEQ_BITS-1:0]     retx_cnt;
  logic [SEQ_BITS-1:0]     ack_base;
  logic [SEQ_BITS-1:0]     rd_seq;
  logic [PAYLOAD_BITS-1:0] rd_data;
  logic                    retx_last;
  logic                    load;
  logic                    out_valid_next;

  logic                    r_acc;
  logic                    r_txv;
  logic [SEQ_BITS-1:0]     r_seq;
  logic [PAYLOAD_BITS-1:0] r_pl;
  timer_cmd_t              r_tcmd;
  logic                    r_last;
  logic [SEQ_BITS-1:0]     window_base_next;
  logic [SEQ_BITS-1:0]     next_sequence_next;
  logic                    store_we;

  assign act         = action_t'(action);
  assign outstanding = next_sequence - window_base;
  assign eff_win     = (window_size > WIN_MAX) ? SEQ_BITS'(WIN_MAX) : SEQ_BITS'(window_size);
  assign retx_cnt    = ({1'b0, outstanding} > (SEQ_BITS+1)'(MAX_RESULTS)) ?
                       SEQ_BITS'(MAX_RESULTS) : outstanding;
  assign ack_base    = ack_number + SEQ_BITS'(1);
  assign retx_last   = ({1'b0, idx} + (SEQ_BITS+1)'(1)) == {1'b0, cnt};
  assign load        = cmd.accept || cmd.step;

  // Read the store at the base, or at the current retransmission slot
  assign rd_seq  = cmd.step ? (window_base + idx) : window_base;
  assign rd_data = payload_store[rd_seq];

  // Status to the controller
  assign status.out_valid = out_valid;
  assign status.multi     = (act == ACT_TIMEOUT) && (retx_cnt > SEQ_BITS'(1));
  assign status.retx_last = retx_last;

  // Form the result and the next window state
  always_comb begin
    r_acc              = 1'b1;
    r_txv              = 1'b0;
    r_seq              = rd_seq;
    r_pl               = rd_data;
    r_tcmd             = TMR_NONE;
    r_last             = 1'b1;
    window_base_next   = window_base;
    next_sequence_next = next_sequence;
    store_we           = 1'b0;
    if (cmd.step) begin
      r_txv  = 1'b1;
      r_last = retx_last;
    end else begin
      unique case (act)
        ACT_SEND: begin
          if (outstanding >= eff_win) begin
            r_acc = 1'b0;
          end else begin
            r_txv              = 1'b1;
            r_seq              = next_sequence;
            r_pl               = payload;
            r_tcmd             = (window_base == next_sequence) ? TMR_START : TMR_NONE;
            next_sequence_next = next_sequence + SEQ_BITS'(1);
            store_we           = cmd.accept;
          end
        end
        ACT_ACK: begin
          if (ack_intact) begin
            window_base_next = ack_base;
            r_tcmd           = (ack_base == next_sequence) ? TMR_STOP : TMR_RESTART;
          end
        end
        ACT_TIMEOUT: begin
          if (outstanding != '0) begin
            r_txv  = 1'b1;
            r_tcmd = TMR_START;
            r_last = (retx_cnt == SEQ_BITS'(1));
          end
        end
        default: begin
          r_acc = 1'b1;
        end
      endcase
    end
  end

  // Hold a stalled result, drop a taken one
  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_RESET;
      window_base   <= '0;
      next_sequence <= '0;
      idx           <= '0;
      cnt           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_data;
      end
      if (cmd.accept) begin
        window_base   <= window_base_next;
        next_sequence <= next_sequence_next;
        idx           <= SEQ_BITS'(1);
        cnt           <= retx_cnt;
      end
      if (cmd.step) begin
        idx <= idx + SEQ_BITS'(1);
      end
      out_valid <= out_valid_next;
    end
  end

  // Payload store and output register
  always_ff @(posedge clk) begin
    if (store_we) begin
      payload_store[next_sequence] <= payload;
    end
    if (load) begin
      accepted   <= r_acc;
      tx_valid   <= r_txv;
      tx_seq     <= r_txv ? r_seq : '0;
      tx_payload <= r_txv ? r_pl : '0;
      timer_cmd  <= 2'(r_tcmd);
      timer_seq  <= window_base_next;
      last       <= r_last;
    end
  end

endmodule

@@ hw/rtl/go_back_n_sender_window_unit.sv @@
// A result is registered: it is in the output register the cycle after its item's transfer.
// Send, ack and ignored items are taken at one per cycle while the output is not stalled.
// A timeout with n outstanding (at most 7) gives n results, or one without a packet if n
// is 0, one per cycle unless the output stalls; in_stall stays high meanwhile.
// Reset: window base and next sequence clear, window_size returns to 4, output empties;
// payload store contents are undefined until written and are not cleared.
// ----------------------------------------------------------------------------
// go_back_n_sender_window_unit
// Go-Back-N ARQ sender window: send, acknowledge and timeout handling.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_unit import gbn_snd_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [WIN_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              action,
  input  logic [PAYLOAD_BITS-1:0] payload,
  input  logic [SEQ_BITS-1:0]     ack_number,
  input  logic                    ack_intact,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    accepted,
  output logic                    tx_valid,
  output logic [SEQ_BITS-1:0]     tx_seq,
  output logic [PAYLOAD_BITS-1:0] tx_payload,
  output logic [1:0]              timer_cmd,
  output logic [SEQ_BITS-1:0]     timer_seq,
  output logic                    last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence transfers and retransmission runs
  gbn_snd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Window state, store and output register
  gbn_snd_dp #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .action     (action),
    .payload    (payload),
    .ack_number (ack_number),
    .ack_intact (ack_intact),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted),
    .tx_valid   (tx_valid),
    .tx_seq     (tx_seq),
    .tx_payload (tx_payload),
    .timer_cmd  (timer_cmd),
    .timer_seq  (timer_seq),
    .last       (last)
  );

endmodule

@@ hw/rtl/gbn_snd_chk.sv @@
// ----------------------------------------------------------------------------
// gbn_snd_chk
// Port-level checks for the Go-Back-N sender window unit, bound to the top.
// ----------------------------------------------------------------------------
module gbn_snd_chk import gbn_snd_pkg::*; #(
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    accepted,
  input logic                    tx_valid,
  input logic [PAYLOAD_BITS-1:0] tx_payload,
  input logic [1:0]              timer_cmd,
  input logic                    last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_payload) && $stable(last))
    else $error("stalled result changed");

  // A refused send carries no packet, no timer command and ends its item
  a_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> !tx_valid && (timer_cmd == TMR_NONE) && last)
    else $error("refused send result malformed");

  // Only packet-carrying results can be followed within the same item
  a_nopkt_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> last)
    else $error("result without packet not final");

  // A retransmission run continues in the very next cycle
  a_run_dense: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && tx_valid && (timer_cmd == TMR_NONE))
    else $error("retransmission run broken");

endmodule

bind go_back_n_sender_window_unit gbn_snd_chk #(
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_gbn_snd_chk (.*);
